[rtl/scta_pkg.sv]
// Shared types, scancode constants and the key lookup table of the scancode translator.
package scta_pkg;

	// Scancode set 1 codes with special handling
	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
	localparam logic [7:0] SC_CTRL       = 8'h1D;
	localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_KEY_C      = 8'h2E;
	localparam logic [7:0] SC_UP         = 8'h48;
	localparam logic [7:0] SC_DOWN       = 8'h50;
	localparam logic [7:0] SC_RIGHT      = 8'h4D;
	localparam logic [7:0] SC_LEFT       = 8'h4B;
	localparam logic [7:0] SC_PGUP       = 8'h49;
	localparam logic [7:0] SC_PGDN       = 8'h51;
	localparam logic [7:0] SC_DEL        = 8'h53;

	// Codes below this limit map through the key table
	localparam logic [7:0] SC_TABLE_LIMIT = 8'd58;

	// Characters of the arrow escape sequence
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_B       = 8'h42;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_D       = 8'h44;

	// Position of the final word of an arrow sequence
	localparam logic [1:0] ARROW_LAST_POS = 2'd2;

	typedef struct packed {
		logic ext;
		logic shift;
		logic ctrl;
		logic caps;
	} flags_t;

	typedef enum logic [1:0] {
		RUN_NONE  = 2'd0,
		RUN_CHAR  = 2'd1,
		RUN_ARROW = 2'd2
	} run_kind_t;

	typedef struct packed {
		run_kind_t   kind;
		logic [7:0]  char_code;
		flags_t      flags_next;
	} decode_t;

	// Look up a table code; letters follow shift xor caps, other keys follow shift
	function automatic logic [7:0] key_lookup(input logic [5:0] code, input logic shift,
		input logic caps);
		logic [15:0] pair;
		logic [7:0]  plain_ch;
		logic        is_letter;
		case (code)
			6'd1:  pair = {8'h1B, 8'h1B};
			6'd2:  pair = {"1", "!"};
			6'd3:  pair = {"2", "@"};
			6'd4:  pair = {"3", "#"};
			6'd5:  pair = {"4", "$"};
			6'd6:  pair = {"5", "%"};
			6'd7:  pair = {"6", "^"};
			6'd8:  pair = {"7", "&"};
			6'd9:  pair = {"8", "*"};
			6'd10: pair = {"9", "("};
			6'd11: pair = {"0", ")"};
			6'd12: pair = {"-", "_"};
			6'd13: pair = {"=", "+"};
			6'd14: pair = {8'h08, 8'h08};
			6'd15: pair = {8'h09, 8'h09};
			6'd16: pair = {"q", "q"};
			6'd17: pair = {"w", "w"};
			6'd18: pair = {"e", "e"};
			6'd19: pair = {"r", "r"};
			6'd20: pair = {"t", "t"};
			6'd21: pair = {"y", "y"};
			6'd22: pair = {"u", "u"};
			6'd23: pair = {"i", "i"};
			6'd24: pair = {"o", "o"};
			6'd25: pair = {"p", "p"};
			6'd26: pair = {8'h5B, 8'h7B};
			6'd27: pair = {8'h5D, 8'h7D};
			6'd28: pair = {8'h0A, 8'h0A};
			6'd30: pair = {"a", "a"};
			6'd31: pair = {"s", "s"};
			6'd32: pair = {"d", "d"};
			6'd33: pair = {"f", "f"};
			6'd34: pair = {"g", "g"};
			6'd35: pair = {"h", "h"};
			6'd36: pair = {"j", "j"};
			6'd37: pair = {"k", "k"};
			6'd38: pair = {"l", "l"};
			6'd39: pair = {8'h3B, 8'h3A};
			6'd40: pair = {8'h27, 8'h22};
			6'd41: pair = {8'h60, 8'h7E};
			6'd43: pair = {8'h5C, 8'h7C};
			6'd44: pair = {"z", "z"};
			6'd45: pair = {"x", "x"};
			6'd46: pair = {"c", "c"};
			6'd47: pair = {"v", "v"};
			6'd48: pair = {"b", "b"};
			6'd49: pair = {"n", "n"};
			6'd50: pair = {"m", "m"};
			6'd51: pair = {8'h2C, 8'h3C};
			6'd52: pair = {8'h2E, 8'h3E};
			6'd53: pair = {8'h2F, 8'h3F};
			6'd57: pair = {8'h20, 8'h20};
			default: pair = 16'h0000;
		endcase
		plain_ch  = pair[15:8];
		is_letter = (plain_ch >= 8'h61) && (plain_ch <= 8'h7A);
		if (is_letter) begin
			key_lookup = (shift ^ caps) ? (plain_ch - 8'h20) : plain_ch;
		end else begin
			key_lookup = shift ? pair[7:0] : plain_ch;
		end
	endfunction

endpackage

[rtl/scancode_to_ascii_translator.sv]
// Top level of the scancode set 1 to ASCII translator.
// Takes one scancode byte per word and returns its ASCII bytes, one per output word,
// with last_of_run high on the final byte of each code's output. A scancode is taken
// every cycle unless the code held in the input register waits for a busy run register;
// the decode sits between the input register and the run register. Modifier, prefix and
// dropped codes produce no word; table keys produce one; extended arrows produce the
// three-word sequence ESC [ A/B/C/D, which holds the run register until its last word
// is taken, so the input stalls behind each arrow. Shift, ctrl, caps lock and the
// prefix flag clear on reset.
module scancode_to_ascii_translator
	import scta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scancode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_code,
	output logic       last_of_run
);

	logic       valid_s1;
	logic [7:0] code_s1;
	flags_t     flags_q;
	decode_t    dec;

	logic       run_valid_q;
	logic       run_arrow_q;
	logic [1:0] run_pos_q;
	logic [7:0] run_char_q;

	logic out_fire;
	logic run_done;
	logic run_free;
	logic advance;

	scta_decode u_decode (
		.scancode (code_s1),
		.flags    (flags_q),
		.dec      (dec)
	);

	assign out_fire = out_valid && out_ready;
	assign run_done = out_fire && last_of_run;
	assign run_free = !run_valid_q || run_done;
	assign advance  = valid_s1 && run_free;
	assign in_ready = !valid_s1 || advance;

	// hold the accepted scancode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= scancode;
		end
	end

	// advance the modifier flags as each code is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (advance) begin
			flags_q <= dec.flags_next;
		end
	end

	// load a new run or step the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_pos_q   <= 2'd0;
		end else if (advance && dec.kind != RUN_NONE) begin
			run_valid_q <= 1'b1;
			run_pos_q   <= 2'd0;
		end else if (run_done) begin
			run_valid_q <= 1'b0;
		end else if (out_fire) begin
			run_pos_q <= run_pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.kind != RUN_NONE) begin
			run_arrow_q <= (dec.kind == RUN_ARROW);
			run_char_q  <= dec.char_code;
		end
	end

	// select the word of the current run
	always_comb begin
		char_code = run_char_q;
		if (run_arrow_q) begin
			case (run_pos_q)
				2'd0:    char_code = CH_ESC;
				2'd1:    char_code = CH_BRACKET;
				default: char_code = run_char_q;
			endcase
		end
	end

	assign out_valid   = run_valid_q;
	assign last_of_run = !run_arrow_q || (run_pos_q == ARROW_LAST_POS);

endmodule

[rtl/scta_decode.sv]
// Scancode decoder: works out the output run and the next modifier flags for one code.
module scta_decode
	import scta_pkg::*;
(
	input  logic [7:0] scancode,
	input  flags_t     flags,
	output decode_t    dec
);

	always_comb begin
		logic handled;
		dec.kind       = RUN_NONE;
		dec.char_code  = 8'h00;
		dec.flags_next = flags;
		handled        = 1'b0;

		if (scancode == SC_PREFIX) begin
			// arm the prefix flag for the next code
			dec.flags_next.ext = 1'b1;
			handled            = 1'b1;
		end else begin
			dec.flags_next.ext = 1'b0;
			// extended keys
			if (flags.ext) begin
				handled = 1'b1;
				unique case (scancode)
					SC_UP: begin
						dec.kind      = RUN_ARROW;
						dec.char_code = CH_A;
					end
					SC_DOWN: begin
						dec.kind      = RUN_ARROW;
						dec.char_code = CH_B;
					end
					SC_RIGHT: begin
						dec.kind      = RUN_ARROW;
						dec.char_code = CH_C;
					end
					SC_LEFT: begin
						dec.kind      = RUN_ARROW;
						dec.char_code = CH_D;
					end
					SC_PGUP, SC_PGDN, SC_DEL: begin
						dec.kind = RUN_NONE;
					end
					SC_CTRL: begin
						dec.flags_next.ctrl = 1'b1;
					end
					SC_CTRL_REL: begin
						dec.flags_next.ctrl = 1'b0;
					end
					default: begin
						handled = 1'b0;
					end
				endcase
			end

			// drop C while ctrl is held
			if (!handled && flags.ctrl && scancode == SC_KEY_C) begin
				handled = 1'b1;
			end

			// modifier keys and table lookup
			if (!handled) begin
				unique case (scancode)
					SC_LSHIFT, SC_RSHIFT: begin
						dec.flags_next.shift = 1'b1;
					end
					SC_LSHIFT_REL, SC_RSHIFT_REL: begin
						dec.flags_next.shift = 1'b0;
					end
					SC_CTRL: begin
						dec.flags_next.ctrl = 1'b1;
					end
					SC_CTRL_REL: begin
						dec.flags_next.ctrl = 1'b0;
					end
					SC_CAPS: begin
						dec.flags_next.caps = ~flags.caps;
					end
					default: begin
						if (scancode < SC_TABLE_LIMIT) begin
							dec.kind      = RUN_CHAR;
							dec.char_code = key_lookup(scancode[5:0], flags.shift,
								flags.caps);
						end
					end
				endcase
			end
		end
	end

endmodule

[rtl/scta_checker.sv]
// Port checker for the scancode translator, bound to the top level.
module scta_checker
	import scta_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_code,
	input logic       last_of_run
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_of_run))
		else $error("output word changed while stalled");

	// with no word pending the input is never blocked
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a run continues without a gap once started
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// ESC inside a run is followed by the bracket
	a_esc_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run && char_code == CH_ESC
		|=> char_code == CH_BRACKET && !last_of_run)
		else $error("escape not followed by bracket");

	// the bracket closes the run with an arrow letter
	a_bracket_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run && char_code == CH_BRACKET
		|=> last_of_run && (char_code == CH_A || char_code == CH_B
			|| char_code == CH_C || char_code == CH_D))
		else $error("bracket not followed by arrow letter");

endmodule

bind scancode_to_ascii_translator scta_checker u_scta_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.char_code   (char_code),
	.last_of_run (last_of_run)
);

[dv/scancode_to_ascii_translator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the scancode set 1 to ASCII translator.
module scancode_to_ascii_translator_tb
	import scta_pkg::*;
();

	localparam int IDLE_LIMIT       = 2000;
	localparam int TOTAL_ITEMS      = 230;
	localparam int DRAIN_EVERY      = 70;
	localparam int LONG_HOLD_AT     = 60;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES      = 10;
	localparam logic [7:0] BREAK_BIT = 8'h80;

	typedef struct packed {
		logic [7:0] code;
		logic       drain;
	} scan_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] scancode = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] char_code;
	logic       last_of_run;

	scancode_to_ascii_translator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scancode   (scancode),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_code  (char_code),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// Keyboard state mirrored by the translation predictor
	logic ext_armed  = 1'b0;
	logic shift_down = 1'b0;
	logic ctrl_down  = 1'b0;
	logic caps_lock  = 1'b0;

	logic [7:0] keys_plain   [0:57];
	logic [7:0] keys_shifted [0:57];

	scan_item_t pending_codes[$];
	char_word_t expected_chars[$];

	int   words_offered = 0;
	int   words_taken   = 0;
	int   mismatches    = 0;
	int   quiet_cycles  = 0;
	int   send_gap      = 0;
	int   ready_gap     = 0;
	int   hold_left     = 0;
	logic held_once     = 1'b0;
	logic drain_request = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 50);
	endfunction

	// Stretches of the run without idling, by progress through the stream
	function automatic int calm_bucket();
		return (words_taken / 30) % 4;
	endfunction

	function automatic logic [7:0] pick_arrow();
		case ($urandom_range(0, 3))
			0: return SC_UP;
			1: return SC_DOWN;
			2: return SC_RIGHT;
			default: return SC_LEFT;
		endcase
	endfunction

	// Look up a table key under the current shift and caps lock
	function automatic logic [7:0] key_char(input logic [7:0] code);
		logic [7:0] ch;
		if (shift_down) begin
			ch = keys_shifted[code];
			if (caps_lock && ch >= "A" && ch <= "Z")
				ch = ch + 8'h20;
		end else begin
			ch = keys_plain[code];
			if (caps_lock && ch >= "a" && ch <= "z")
				ch = ch - 8'h20;
		end
		return ch;
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic last);
		char_word_t w;
		w.ch   = ch;
		w.last = last;
		expected_chars.push_back(w);
	endtask

	task automatic push_arrow(input logic [7:0] letter);
		push_char(CH_ESC, 1'b0);
		push_char(CH_BRACKET, 1'b0);
		push_char(letter, 1'b1);
	endtask

	// Advance the keyboard state by one scancode and queue the chars it yields
	task automatic predict_chars(input logic [7:0] code);
		logic handled;
		handled = 1'b0;
		if (code == SC_PREFIX) begin
			ext_armed = 1'b1;
			handled = 1'b1;
		end else if (ext_armed) begin
			ext_armed = 1'b0;
			handled = 1'b1;
			case (code)
				SC_UP:                    push_arrow(CH_A);
				SC_DOWN:                  push_arrow(CH_B);
				SC_RIGHT:                 push_arrow(CH_C);
				SC_LEFT:                  push_arrow(CH_D);
				SC_PGUP, SC_PGDN, SC_DEL: ;
				SC_CTRL:                  ctrl_down = 1'b1;
				SC_CTRL_REL:              ctrl_down = 1'b0;
				default:                  handled = 1'b0;
			endcase
		end
		// Ctrl-C is swallowed; everything else goes through normal handling
		if (!handled && !(ctrl_down && code == SC_KEY_C)) begin
			case (code)
				SC_LSHIFT, SC_RSHIFT:         shift_down = 1'b1;
				SC_LSHIFT_REL, SC_RSHIFT_REL: shift_down = 1'b0;
				SC_CTRL:                      ctrl_down = 1'b1;
				SC_CTRL_REL:                  ctrl_down = 1'b0;
				SC_CAPS:                      caps_lock = ~caps_lock;
				default: begin
					if (code < SC_TABLE_LIMIT)
						push_char(key_char(code), 1'b1);
				end
			endcase
		end
	endtask

	task automatic queue_code(input logic [7:0] code);
		scan_item_t item;
		item.code = code;
		item.drain = drain_request;
		drain_request = 1'b0;
		pending_codes.push_back(item);
	endtask

	// Build mostly well-formed key sequences with random content, plus noise
	task automatic queue_random_events();
		int         r;
		int         next_drain;
		int         n;
		logic [7:0] k;
		logic [7:0] mod;
		next_drain = DRAIN_EVERY;
		while (pending_codes.size() < TOTAL_ITEMS) begin
			if (pending_codes.size() >= next_drain) begin
				drain_request = 1'b1;
				next_drain += DRAIN_EVERY;
			end
			r = $urandom_range(0, 99);
			if (r < 38) begin
				// table key, often with its break code
				k = 8'($urandom_range(0, 57));
				queue_code(k);
				if ($urandom_range(0, 1))
					queue_code(k | BREAK_BIT);
			end else if (r < 55) begin
				// extended arrow, sometimes with its extended break
				queue_code(SC_PREFIX);
				k = pick_arrow();
				queue_code(k);
				if ($urandom_range(0, 2) == 0) begin
					queue_code(SC_PREFIX);
					queue_code(k | BREAK_BIT);
				end
			end else if (r < 66) begin
				// shifted run of keys
				mod = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
				queue_code(mod);
				n = $urandom_range(1, 4);
				repeat (n) queue_code(8'($urandom_range(0, 57)));
				queue_code(mod | BREAK_BIT);
			end else if (r < 75) begin
				// ctrl held around a key, C often among them
				if ($urandom_range(0, 1))
					queue_code(SC_PREFIX);
				queue_code(SC_CTRL);
				queue_code($urandom_range(0, 1) ? SC_KEY_C : 8'($urandom_range(0, 57)));
				if ($urandom_range(0, 3) != 0) begin
					if ($urandom_range(0, 1))
						queue_code(SC_PREFIX);
					queue_code(SC_CTRL_REL);
				end
			end else if (r < 81) begin
				queue_code(SC_CAPS);
				if ($urandom_range(0, 1))
					queue_code(SC_CAPS | BREAK_BIT);
			end else if (r < 89) begin
				// extended non-arrow keys and extended fall-through codes
				queue_code(SC_PREFIX);
				case ($urandom_range(0, 3))
					0: queue_code(SC_PGUP);
					1: queue_code(SC_PGDN);
					2: queue_code(SC_DEL);
					default: queue_code(8'($urandom_range(0, 255)));
				endcase
			end else if (r < 93) begin
				// broken sequence: doubled prefix or prefix before a break
				queue_code(SC_PREFIX);
				queue_code($urandom_range(0, 1) ? SC_PREFIX : 8'($urandom_range(128, 255)));
				queue_code(pick_arrow());
			end else begin
				queue_code(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Drive scancode words at the falling edge
	always @(negedge clk) begin : drive_scancodes
		scan_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (words_taken == words_offered) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_codes.size() == 0 ||
				(pending_codes[0].drain && expected_chars.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				item = pending_codes.pop_front();
				scancode <= item.code;
				in_valid <= 1'b1;
				words_offered++;
				if (calm_bucket() != 1 && calm_bucket() != 3)
					send_gap = pick_gap();
			end
		end
	end

	// Throttle the output side, with one long hold-off to back up the input
	always @(negedge clk) begin : drive_out_ready
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!held_once && words_taken >= LONG_HOLD_AT) begin
			held_once = 1'b1;
			hold_left = LONG_HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (ready_gap > 0) begin
			out_ready <= 1'b0;
			ready_gap--;
		end else begin
			out_ready <= 1'b1;
			if (calm_bucket() < 2)
				ready_gap = pick_gap();
		end
	end

	// Check output words and predict from accepted scancodes
	always @(posedge clk) begin : check_chars
		char_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				$error("char_code: no word expected, got %02h last_of_run %b",
					char_code, last_of_run);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (char_code !== want.ch) begin
					$error("char_code: expected %02h, got %02h", want.ch, char_code);
					mismatches++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, last_of_run);
					mismatches++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			predict_chars(scancode);
			words_taken <= words_taken + 1;
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		keys_plain = '{
			8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
			"q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00, "a", "s",
			"d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'h00, 8'h5C, "z", "x", "c", "v",
			"b", "n", "m", ",", ".", "/", 8'h00, 8'h00, 8'h00, " "
		};
		keys_shifted = '{
			8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
			"Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00, "A", "S",
			"D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'h00, "|", "Z", "X", "C", "V",
			"B", "N", "M", "<", ">", "?", 8'h00, 8'h00, 8'h00, " "
		};

		// Directed: table edges, zero entries, caps and shift combinations
		queue_code(8'h00);
		queue_code(8'h01);
		queue_code(8'h39);
		queue_code(8'h37);
		queue_code(8'h10);
		queue_code(SC_CAPS);
		queue_code(8'h10);
		queue_code(SC_LSHIFT);
		queue_code(8'h10);
		queue_code(8'h35);
		queue_code(SC_LSHIFT_REL);
		queue_code(SC_CAPS);
		queue_code(SC_RSHIFT);
		queue_code(8'h02);
		queue_code(SC_RSHIFT_REL);
		// Directed: arrows and the silent extended keys
		queue_code(SC_PREFIX); queue_code(SC_UP);
		queue_code(SC_PREFIX); queue_code(SC_DOWN);
		queue_code(SC_PREFIX); queue_code(SC_RIGHT);
		queue_code(SC_PREFIX); queue_code(SC_LEFT);
		queue_code(SC_PREFIX); queue_code(SC_PGUP);
		queue_code(SC_PREFIX); queue_code(SC_PGDN);
		queue_code(SC_PREFIX); queue_code(SC_DEL);
		// Directed: ctrl-C dropped under both ctrl forms, then C passes again
		queue_code(SC_PREFIX); queue_code(SC_CTRL);
		queue_code(SC_KEY_C);
		queue_code(SC_PREFIX); queue_code(SC_CTRL_REL);
		queue_code(SC_CTRL);
		queue_code(SC_KEY_C);
		queue_code(SC_CTRL_REL);
		queue_code(SC_KEY_C);
		// Directed: extended fall-through, doubled prefix, codes past the table
		queue_code(SC_PREFIX); queue_code(8'h1E);
		queue_code(SC_PREFIX); queue_code(SC_PREFIX); queue_code(SC_UP);
		queue_code(SC_TABLE_LIMIT);
		queue_code(8'h56);
		queue_code(8'hFF);
		queue_code(BREAK_BIT);

		drain_request = 1'b1;
		queue_random_events();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_codes.size() != 0 || words_taken != words_offered ||
			expected_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0) begin
			$error("char_code: %0d expected words never arrived", expected_chars.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[scancode_to_ascii_translator.f]
rtl/scta_pkg.sv
rtl/scta_decode.sv
rtl/scancode_to_ascii_translator.sv
rtl/scta_checker.sv
dv/scancode_to_ascii_translator_tb.sv
